/* rtl/core/cfuv_pkg.sv */
// Package for the cube-map face selection block: payload structs, face codes
// and the per-cell pipeline record. No dependencies.
package cfuv_pkg;

    localparam int COMP_BITS  = 16;
    localparam int FRAC_BITS  = 14;
    localparam int COORD_BITS = FRAC_BITS + 2;
    localparam int MAG_BITS   = COMP_BITS;          // magnitude fits unsigned
    localparam int QUO_BITS   = FRAC_BITS + 1;      // quotient 0..2^FRAC_BITS

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    typedef struct packed {
        logic signed [COMP_BITS-1:0] dir_x;
        logic signed [COMP_BITS-1:0] dir_y;
        logic signed [COMP_BITS-1:0] dir_z;
    } dir_in_t;

    typedef struct packed {
        logic [2:0]                   face;
        logic signed [COORD_BITS-1:0] u_coord;
        logic signed [COORD_BITS-1:0] v_coord;
        logic                         degenerate;
    } uv_out_t;

    // Record handed from cell to cell: two restoring dividers side by side
    typedef struct packed {
        logic                valid;
        logic [2:0]          face;
        logic                degenerate;
        logic                neg_u;
        logic                neg_v;
        logic [MAG_BITS-1:0] den;
        logic [MAG_BITS:0]   rem_u;
        logic [MAG_BITS:0]   rem_v;
        logic [MAG_BITS-1:0] num_u;   // numerator bits still to shift in
        logic [MAG_BITS-1:0] num_v;
        logic [QUO_BITS-1:0] quo_u;
        logic [QUO_BITS-1:0] quo_v;
    } cell_t;

endpackage

/* rtl/core/cfuv_cell.sv */
// One restoring-division cell: brings down one numerator bit for u and v and
// produces one quotient bit each. Depends on cfuv_pkg.
module cfuv_cell
    import cfuv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cell_t cell_in,
    output cell_t cell_out
);

    cell_t cell_reg;
    cell_t cell_next;

    logic [MAG_BITS:0] trial_u;
    logic [MAG_BITS:0] trial_v;
    logic              ge_u;
    logic              ge_v;

    // Shift in the next numerator bit and compare against the divisor
    always_comb
    begin
        cell_next = cell_in;
        trial_u   = {cell_in.rem_u[MAG_BITS-1:0], cell_in.num_u[MAG_BITS-1]};
        trial_v   = {cell_in.rem_v[MAG_BITS-1:0], cell_in.num_v[MAG_BITS-1]};
        ge_u      = trial_u >= {1'b0, cell_in.den};
        ge_v      = trial_v >= {1'b0, cell_in.den};
        cell_next.rem_u = ge_u ? trial_u - {1'b0, cell_in.den} : trial_u;
        cell_next.rem_v = ge_v ? trial_v - {1'b0, cell_in.den} : trial_v;
        cell_next.num_u = {cell_in.num_u[MAG_BITS-2:0], 1'b0};
        cell_next.num_v = {cell_in.num_v[MAG_BITS-2:0], 1'b0};
        cell_next.quo_u = {cell_in.quo_u[QUO_BITS-2:0], ge_u};
        cell_next.quo_v = {cell_in.quo_v[QUO_BITS-2:0], ge_v};
    end

    // Advance the record to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

/* rtl/core/cfuv_select.sv */
// Front stage: major-axis selection, face code, sign handling and loading of
// the first division record. Depends on cfuv_pkg.
module cfuv_select
    import cfuv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  dir_in_t dir,
    output cell_t   cell_out
);

    cell_t cell_reg;
    cell_t cell_next;

    logic [MAG_BITS-1:0] ax, ay, az;
    logic                nx, ny, nz;
    logic                zero_vec;

    // Magnitudes are exact: the most negative value maps to 2^(n-1)
    always_comb
    begin
        nx = dir.dir_x[COMP_BITS-1];
        ny = dir.dir_y[COMP_BITS-1];
        nz = dir.dir_z[COMP_BITS-1];
        ax = nx ? MAG_BITS'(-dir.dir_x) : MAG_BITS'(dir.dir_x);
        ay = ny ? MAG_BITS'(-dir.dir_y) : MAG_BITS'(dir.dir_y);
        az = nz ? MAG_BITS'(-dir.dir_z) : MAG_BITS'(dir.dir_z);
        zero_vec = (ax == '0) && (ay == '0) && (az == '0);
    end

    // Pick the face and the minor numerators with their result signs
    always_comb
    begin
        cell_next            = '0;
        cell_next.valid      = load;
        cell_next.degenerate = zero_vec;
        if (zero_vec)
        begin
            // Unit divisor with zero numerators keeps both quotients at zero
            cell_next.face = FACE_NEG_X;
            cell_next.den  = MAG_BITS'(1);
        end
        else if (ax >= ay && ax >= az)
        begin
            cell_next.face  = nx ? FACE_NEG_X : FACE_POS_X;
            cell_next.den   = ax;
            cell_next.num_u = az;
            cell_next.neg_u = (az != '0) && (nz == nx);         // -z/x
            cell_next.num_v = ay;
            // face 0: y/x, face 1: -y/x; both equal |y|/|x| signed by y
            cell_next.neg_v = (ay != '0) && ny;
        end
        else if (ay >= az)
        begin
            cell_next.face  = ny ? FACE_NEG_Y : FACE_POS_Y;
            cell_next.den   = ay;
            cell_next.num_u = ax;
            cell_next.neg_u = (ax != '0) && nx;                 // x/y or -x/-y
            cell_next.num_v = az;
            cell_next.neg_v = (az != '0) && (nz == ny);         // -z/y
        end
        else
        begin
            cell_next.face  = nz ? FACE_NEG_Z : FACE_POS_Z;
            cell_next.den   = az;
            cell_next.num_u = ax;
            cell_next.neg_u = (ax != '0) && (nx != nz);         // x/z
            cell_next.num_v = ay;
            cell_next.neg_v = (ay != '0) && ny;                 // y/z or -y/-z
        end
    end

    // Hold the first division record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

/* rtl/core/cube_face_uv_from_direction_top.sv */
// Cube-map face selection top level: select stage, chain of division cells
// and output register. Depends on cfuv_pkg, cfuv_select and cfuv_cell.
//
// One direction vector is taken per clock (busy never rises) and each
// result appears with done high after passing through the select register,
// the chain of restoring-division cells, one quotient bit per cell, that
// computes u and v side by side, and the output register. Results cannot
// be held off.
module cube_face_uv_from_direction_top
    import cfuv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  dir_in_t dir,
    output logic    done,
    output uv_out_t result
);

    // Dividend |n| * 2^F, |n| <= |m|: quotient bits beyond F+1 are zero, so
    // the chain runs over the magnitude bits then the F fraction bits.
    localparam int STEPS = COMP_BITS + FRAC_BITS;

    cell_t chain [STEPS+1];

    logic    accept;
    uv_out_t result_reg;
    uv_out_t result_next;
    logic    done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cfuv_select u_select (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (accept),
        .dir      (dir),
        .cell_out (chain[0])
    );

    // Row of division cells, one quotient bit each
    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        cfuv_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_in  (chain[i]),
            .cell_out (chain[i+1])
        );
    end

    // Apply signs and drop to the output register
    always_comb
    begin
        result_next.face       = chain[STEPS].face;
        result_next.degenerate = chain[STEPS].degenerate;
        result_next.u_coord    = chain[STEPS].neg_u
                               ? -$signed({1'b0, chain[STEPS].quo_u})
                               :  $signed({1'b0, chain[STEPS].quo_u});
        result_next.v_coord    = chain[STEPS].neg_v
                               ? -$signed({1'b0, chain[STEPS].quo_v})
                               :  $signed({1'b0, chain[STEPS].quo_v});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= chain[STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // A zero vector always reports face 1 with zero coordinates
    a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.degenerate |->
            result.face == FACE_NEG_X && result.u_coord == '0 && result.v_coord == '0)
        else $error("degenerate result not forced");

    // Face code stays within the six faces
    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.face <= FACE_NEG_Z)
        else $error("face code out of range");

    // Coordinates never exceed one in magnitude
    a_coord_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.u_coord <= 16'sd16384 && result.u_coord >= -16'sd16384
              && result.v_coord <= 16'sd16384 && result.v_coord >= -16'sd16384)
        else $error("coordinate beyond unit range");

endmodule

/* dv/cube_face_uv_from_direction_top_tb.sv */
// Testbench for cube_face_uv_from_direction_top: directed and random direction
// vectors, checked against an in-bench face/uv predictor. Depends on cfuv_pkg.
`timescale 1ns / 1ps

module cube_face_uv_from_direction_top_tb;
    import cfuv_pkg::*;

    localparam int LATENCY = COMP_BITS + FRAC_BITS + 2;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    dir_in_t dir;
    logic    done;
    uv_out_t result;

    uv_out_t expected_uv_q[$];
    int      fail_count;

    cube_face_uv_from_direction_top uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .dir    (dir),
        .done   (done),
        .result (result)
    );

    // Generate the clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Give up after a generous fixed time
    initial
    begin
        #20ms;
        $display("status: fail");
        $finish;
    end

    // Divide n by d in signed Q1.14, truncated toward zero
    function automatic logic signed [COORD_BITS-1:0] fixed_ratio(longint n, longint d);
        longint nm;
        longint dm;
        longint q;
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        if (dm == 0)
            return '0;
        q = (nm << FRAC_BITS) / dm;
        if ((n < 0) != (d < 0))
            q = -q;
        return q[COORD_BITS-1:0];
    endfunction

    // Work out face, u and v for one direction
    function automatic uv_out_t face_uv_of(dir_in_t d);
        uv_out_t r;
        longint  x, y, z, ax, ay, az, m, nu, nv;
        face_t   f;
        x = d.dir_x;
        y = d.dir_y;
        z = d.dir_z;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        r = '0;
        if (x == 0 && y == 0 && z == 0)
        begin
            r.face = FACE_NEG_X;
            r.degenerate = 1'b1;
            return r;
        end
        if (ax >= ay && ax >= az)
        begin
            m = x;
            nu = -z;
            if (x > 0) begin f = FACE_POS_X; nv = y; end
            else begin f = FACE_NEG_X; nv = -y; end
        end
        else if (ay >= az)
        begin
            m = y;
            nv = -z;
            if (y > 0) begin f = FACE_POS_Y; nu = x; end
            else begin f = FACE_NEG_Y; nu = -x; end
        end
        else
        begin
            m = z;
            nu = x;
            if (z > 0) begin f = FACE_POS_Z; nv = y; end
            else begin f = FACE_NEG_Z; nv = -y; end
        end
        r.face = f;
        r.u_coord = fixed_ratio(nu, m);
        r.v_coord = fixed_ratio(nv, m);
        return r;
    endfunction

    // Compare each result with the oldest expectation
    initial
    begin
        uv_out_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && done)
            begin
                if (expected_uv_q.size() == 0)
                begin
                    $error("unexpected result: face %0d", result.face);
                    fail_count++;
                end
                else
                begin
                    want = expected_uv_q.pop_front();
                    if (result.face !== want.face)
                    begin
                        $error("face: expected %0d, got %0d", want.face, result.face);
                        fail_count++;
                    end
                    if (result.u_coord !== want.u_coord)
                    begin
                        $error("u_coord: expected %0d, got %0d", want.u_coord, result.u_coord);
                        fail_count++;
                    end
                    if (result.v_coord !== want.v_coord)
                    begin
                        $error("v_coord: expected %0d, got %0d", want.v_coord, result.v_coord);
                        fail_count++;
                    end
                    if (result.degenerate !== want.degenerate)
                    begin
                        $error("degenerate: expected %0d, got %0d",
                               want.degenerate, result.degenerate);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Send one vector, with an optional gap of idle cycles before it
    task automatic send_dir(int x, int y, int z, int gap);
        dir_in_t d;
        d.dir_x = COMP_BITS'(x);
        d.dir_y = COMP_BITS'(y);
        d.dir_z = COMP_BITS'(z);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        dir <= d;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_uv_q.push_back(face_uv_of(d));
    endtask

    // Short gaps mostly, a few long, and stretches with none
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    function automatic logic signed [15:0] random_component();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'sh8000;
        if (r == 1)
            return 16'sh7fff;
        if (r == 2)
            return 16'($urandom_range(0, 4) - 2);
        return 16'($urandom());
    endfunction

    // Zero vector, extremes, ties, full-scale quotients and each face
    task automatic test_directed();
        send_dir(0, 0, 0, 0);
        send_dir(16'sh7fff, 0, 0, 0);
        send_dir(16'sh8000, 0, 0, 0);
        send_dir(0, 16'sh7fff, 0, 0);
        send_dir(0, 16'sh8000, 0, 0);
        send_dir(0, 0, 16'sh7fff, 0);
        send_dir(0, 0, 16'sh8000, 0);
        send_dir(16'sh8000, 16'sh8000, 16'sh8000, 0);
        send_dir(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
        send_dir(16'sh7fff, 16'sh8001, 16'sh7fff, 0);
        send_dir(-5, 5, -5, 0);
        send_dir(3, -7, 7, 0);
        send_dir(1, 2, -2, 0);
        send_dir(16'sh8000, 16'sh7fff, -1, 0);
        send_dir(1, 16'sh8000, 16'sh7fff, 0);
        send_dir(-1, 1, 16'sh8000, 0);
        send_dir(1, 0, 0, 0);
        send_dir(-1, 0, 0, 0);
        send_dir(3, 1, 2, 0);
        send_dir(-1, 0, 1, 0);
        send_dir(16'sh5555, 16'shaaaa, 16'sh1234, 0);
        send_dir(16'shaaaa, 16'sh5555, 16'shedcb, 0);
    endtask

    // Random vectors with random gaps
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_dir(random_component(), random_component(), random_component(),
                     random_gap());
    endtask

    // Random vectors with a tie forced between two axes
    task automatic test_ties(int count);
        logic signed [15:0] a;
        logic signed [15:0] b;
        for (int i = 0; i < count; i++)
        begin
            a = random_component();
            b = $urandom_range(0, 1) ? a : -a;
            case ($urandom_range(0, 2))
                0: send_dir(a, b, random_component() >>> 2, random_gap());
                1: send_dir(a, random_component() >>> 2, b, random_gap());
                default: send_dir(random_component() >>> 2, a, b, random_gap());
            endcase
        end
    endtask

    initial
    begin
        fail_count = 0;
        rst_n = 1'b0;
        start = 1'b0;
        dir = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(900);
        test_ties(200);
        start <= 1'b0;
        // Drain the division chain
        for (int w = 0; w < 10 * LATENCY && expected_uv_q.size() != 0; w++)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
        if (fail_count == 0 && expected_uv_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/core/cfuv_pkg.sv
rtl/core/cfuv_cell.sv
rtl/core/cfuv_select.sv
rtl/core/cube_face_uv_from_direction_top.sv
dv/cube_face_uv_from_direction_top_tb.sv
